FILE: rtl/ttmnv_pkg.sv
// ttmnv_pkg: shared types and constants of the tilt to note and volume block
// no dependencies; imported by the interfaces and the top level

package ttmnv_pkg;

   localparam int ACCEL_W   = 16;
   localparam int NOTE_W    = 7;
   localparam int VOL_W     = 11;
   localparam int CNT_W     = 5;

   // square root of (y^2 + z^2) << 16, one result bit per step
   localparam int R2_W       = 32;
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int REM_W      = 26;
   localparam int SQRT_STEPS = 24;

   // cordic datapath width, covers magnitude growth of 256-scaled inputs
   localparam int CW = 28;

   // volume in tenths: (2540*u + 90*deg) / (180*deg) = ((...) >> (frac+2)) / 45
   localparam int VOL_NUM_SCALE   = 2540;
   localparam int VOL_DIV         = 45;
   localparam int VOL_MAX_TENTHS  = 1270;
   localparam int VOL_M_W         = 16;
   localparam int VOL_M_FULL      = VOL_MAX_TENTHS * VOL_DIV;
   localparam int VOL_RECIP       = 46604;
   localparam int VOL_RECIP_W     = 17;
   localparam int VOL_RECIP_SHIFT = 21;

   localparam logic [NOTE_W-1:0] NOTE_C4 = 7'd60;
   localparam logic [NOTE_W-1:0] NOTE_D4 = 7'd62;
   localparam logic [NOTE_W-1:0] NOTE_E4 = 7'd64;
   localparam logic [NOTE_W-1:0] NOTE_F4 = 7'd65;
   localparam logic [NOTE_W-1:0] NOTE_G4 = 7'd67;
   localparam logic [NOTE_W-1:0] NOTE_A4 = 7'd69;
   localparam logic [NOTE_W-1:0] NOTE_B4 = 7'd71;
   localparam logic [NOTE_W-1:0] NOTE_C5 = 7'd72;

   localparam logic [VOL_W-1:0] THRESHOLD_RESET = 11'd50;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQRT,
      ST_PREP,
      ST_ITER,
      ST_ANGLE_DONE,
      ST_VOL,
      ST_DIV,
      ST_DONE
   } ttmnv_state_type;

   // atan(2^-i) in units of 2^-16 degree
   function automatic logic [23:0] atan_entry(input logic [CNT_W-1:0] i);
      logic [23:0] t;
      case (i)
         5'd0:    t = 24'd2949120;
         5'd1:    t = 24'd1740967;
         5'd2:    t = 24'd919879;
         5'd3:    t = 24'd466945;
         5'd4:    t = 24'd234379;
         5'd5:    t = 24'd117304;
         5'd6:    t = 24'd58666;
         5'd7:    t = 24'd29335;
         5'd8:    t = 24'd14668;
         5'd9:    t = 24'd7334;
         5'd10:   t = 24'd3667;
         5'd11:   t = 24'd1833;
         5'd12:   t = 24'd917;
         5'd13:   t = 24'd458;
         5'd14:   t = 24'd229;
         5'd15:   t = 24'd115;
         5'd16:   t = 24'd57;
         5'd17:   t = 24'd29;
         5'd18:   t = 24'd14;
         5'd19:   t = 24'd7;
         5'd20:   t = 24'd4;
         5'd21:   t = 24'd2;
         5'd22:   t = 24'd1;
         default: t = 24'd0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/ttmnv_req_if.sv
// ttmnv_req_if: valid/ready channel carrying one accelerometer sample per beat
// depends on ttmnv_pkg

interface ttmnv_req_if
   import ttmnv_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [ACCEL_W-1:0] accel_x;
   logic signed [ACCEL_W-1:0] accel_y;
   logic signed [ACCEL_W-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

FILE: rtl/ttmnv_rsp_if.sv
// ttmnv_rsp_if: valid/ready channel carrying one note and volume per beat
// depends on ttmnv_pkg

interface ttmnv_rsp_if
   import ttmnv_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] note_number;
   logic [VOL_W-1:0]  volume_tenths;

   modport source (output valid, output note_number, output volume_tenths,
                   input ready);
   modport sink   (input valid, input note_number, input volume_tenths,
                   output ready);
endinterface

FILE: rtl/tilt_to_midi_note_volume_top.sv
// tilt_to_midi_note_volume_top: roll/pitch from one accelerometer sample to note and volume
// depends on ttmnv_pkg, ttmnv_req_if, ttmnv_rsp_if

// One sample is taken at a time. From acceptance to the result the block computes the
// squares of y and z one after the other on one multiplier, then the bit-per-cycle
// square root, then roll and pitch one after the other through the single CORDIC
// rotation stage (its iterations are skipped when a vector lies on an axis or a
// diagonal), then the volume scaling. req_chan.ready is high only while the block is
// idle; a finished beat waits in the output register, and the next sample is accepted
// meanwhile. A beat is sent on the first sample, on a note change, or when the volume
// moved by at least the threshold in tenths (csr_wr_data).

module tilt_to_midi_note_volume_top
   import ttmnv_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   ttmnv_req_if.sink          req_chan,
   ttmnv_rsp_if.source        rsp_chan,
   input  logic               csr_wr_en,
   input  logic [VOL_W-1:0]   csr_wr_data
);

   localparam int AW   = ANGLE_FRAC_BITS + 10;
   localparam int NW   = ANGLE_FRAC_BITS + 19;
   localparam int DEG  = 1 << ANGLE_FRAC_BITS;
   localparam int SH   = 16 - ANGLE_FRAC_BITS;
   localparam int HALF = (1 << SH) >> 1;

   localparam logic signed [AW-1:0] A45  = AW'(45 * DEG);
   localparam logic signed [AW-1:0] A90  = AW'(90 * DEG);
   localparam logic signed [AW-1:0] A135 = AW'(135 * DEG);
   localparam logic signed [AW-1:0] A180 = AW'(180 * DEG);
   localparam logic signed [AW-1:0] D30  = AW'(30 * DEG);
   localparam logic signed [AW-1:0] H1   = AW'(45 * DEG / 2);
   localparam logic signed [AW-1:0] H2   = AW'(45 * DEG);
   localparam logic signed [AW-1:0] H3   = AW'(3 * 45 * DEG / 2);

   ttmnv_state_type state_ff, state_in;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      pass_ff, pass_in;
   logic signed [ACCEL_W-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [R2_W-1:0]           r2_ff, r2_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic signed [CW-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0]      acc_ff, acc_in;
   logic [NOTE_W-1:0]         note_ff, note_in;
   logic [VOL_M_W-1:0]        m_ff, m_in;
   logic [VOL_W-1:0]          vol_ff, vol_in;
   logic                      have_ff, have_in;
   logic [NOTE_W-1:0]         prev_note_ff, prev_note_in;
   logic [VOL_W-1:0]          prev_vol_ff, prev_vol_in;
   logic [VOL_W-1:0]          thr_ff, thr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NOTE_W-1:0]         rsp_note_ff, rsp_note_in;
   logic [VOL_W-1:0]          rsp_vol_ff, rsp_vol_in;

   // shared datapath pieces
   logic signed [ACCEL_W-1:0] mul_a;
   logic signed [R2_W-1:0]    sq;
   logic [REM_W+1:0]          rem_t, trial;
   logic signed [CW-1:0]      xv, yv, xa, ya, xs, ys;
   logic [23:0]               ent;
   logic signed [AW-1:0]      t_w;
   logic [AW-1:0]             u_w;
   logic [NW-1:0]             n_w;
   logic [VOL_M_W+VOL_RECIP_W-1:0] prod;
   logic [NOTE_W-1:0]         note_w;
   logic [VOL_W-1:0]          diff;
   logic                      emit;

   assign mul_a = (state_ff == ST_SQ_Z) ? az_ff : ay_ff;
   assign sq    = mul_a * mul_a;

   assign rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   assign xv = pass_ff ? CW'(root_ff) : CW'(signed'({az_ff, 8'h00}));
   assign yv = pass_ff ? -CW'(signed'({ax_ff, 8'h00})) : CW'(signed'({ay_ff, 8'h00}));
   assign xa = (xv < 0) ? -xv : xv;
   assign ya = (yv < 0) ? -yv : yv;
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   assign ent = (atan_entry(cnt_ff) + 24'(HALF)) >> SH;
   assign t_w = AW'(ent);

   assign u_w  = AW'(acc_ff + D30);
   assign n_w  = NW'(u_w) * NW'(VOL_NUM_SCALE) + NW'(90 * DEG);
   assign prod = m_ff * VOL_RECIP_W'(VOL_RECIP);

   always_comb begin
      if (acc_ff <= -H3) begin
         note_w = NOTE_C4;
      end else if (acc_ff <= -H2) begin
         note_w = NOTE_D4;
      end else if (acc_ff <= -H1) begin
         note_w = NOTE_E4;
      end else if (acc_ff <= 0) begin
         note_w = NOTE_F4;
      end else if (acc_ff <= H1) begin
         note_w = NOTE_G4;
      end else if (acc_ff <= H2) begin
         note_w = NOTE_A4;
      end else if (acc_ff <= H3) begin
         note_w = NOTE_B4;
      end else begin
         note_w = NOTE_C5;
      end
   end

   assign diff = (vol_ff > prev_vol_ff) ? vol_ff - prev_vol_ff : prev_vol_ff - vol_ff;
   assign emit = !have_ff || (note_ff != prev_note_ff) || (diff >= thr_ff);

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.note_number   = rsp_note_ff;
   assign rsp_chan.volume_tenths = rsp_vol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_ff      <= 1'b0;
         prev_note_ff <= '0;
         prev_vol_ff  <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_ff      <= have_in;
         prev_note_ff <= prev_note_in;
         prev_vol_ff  <= prev_vol_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pass_ff     <= pass_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      r2_ff       <= r2_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      note_ff     <= note_in;
      m_ff        <= m_in;
      vol_ff      <= vol_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vol_ff  <= rsp_vol_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      r2_in        = r2_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      note_in      = note_ff;
      m_in         = m_ff;
      vol_in       = vol_ff;
      have_in      = have_ff;
      prev_note_in = prev_note_ff;
      prev_vol_in  = prev_vol_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_note_in  = rsp_note_ff;
      rsp_vol_in   = rsp_vol_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               ax_in    = req_chan.accel_x;
               ay_in    = req_chan.accel_y;
               az_in    = req_chan.accel_z;
               pass_in  = 1'b0;
               state_in = ST_SQ_Y;
            end
         end
         ST_SQ_Y: begin
            r2_in    = unsigned'(sq);
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            rad_in   = {r2_ff + unsigned'(sq), 16'h0000};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_t >= trial) begin
               rem_in  = REM_W'(rem_t - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_t);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cnt_in   = '0;
            state_in = ST_ANGLE_DONE;
            if (yv == 0) begin
               acc_in = (xv >= 0) ? '0 : A180;
            end else if (xv == 0) begin
               acc_in = (yv > 0) ? A90 : -A90;
            end else if (xa == ya) begin
               acc_in = (yv > 0) ? ((xv > 0) ? A45 : A135) : ((xv > 0) ? -A45 : -A135);
            end else begin
               state_in = ST_ITER;
               if (xv < 0) begin
                  if (yv > 0) begin
                     x_in   = yv;
                     y_in   = -xv;
                     acc_in = A90;
                  end else begin
                     x_in   = -yv;
                     y_in   = xv;
                     acc_in = -A90;
                  end
               end else begin
                  x_in   = xv;
                  y_in   = yv;
                  acc_in = '0;
               end
            end
         end
         ST_ITER: begin
            if (y_ff >= 0) begin
               x_in   = x_ff + ys;
               y_in   = y_ff - xs;
               acc_in = acc_ff + t_w;
            end else begin
               x_in   = x_ff - ys;
               y_in   = y_ff + xs;
               acc_in = acc_ff - t_w;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_ANGLE_DONE;
            end
         end
         ST_ANGLE_DONE: begin
            if (!pass_ff) begin
               note_in  = note_w;
               pass_in  = 1'b1;
               state_in = ST_PREP;
            end else begin
               state_in = ST_VOL;
            end
         end
         ST_VOL: begin
            if (acc_ff < -D30) begin
               m_in = VOL_M_W'(VOL_M_FULL);
            end else if (acc_ff > D30) begin
               m_in = '0;
            end else begin
               m_in = VOL_M_W'(n_w >> (ANGLE_FRAC_BITS + 2));
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            vol_in   = VOL_W'(prod >> VOL_RECIP_SHIFT);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_note_in  = note_ff;
                  rsp_vol_in   = vol_ff;
                  have_in      = 1'b1;
                  prev_note_in = note_ff;
                  prev_vol_in  = vol_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ttmnv_checker.sv
// ttmnv_checker: port-level assertions for the tilt to note and volume top level
// depends on tilt_to_midi_note_volume_top; attached by the bind below

module ttmnv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_note,
   input logic [10:0] rsp_volume
);

   // busy after a sample beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a sample beat");

   // a result only follows a busy period
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a sample being worked on");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note) && $stable(rsp_volume))
      else $error("stalled result changed or dropped");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind tilt_to_midi_note_volume_top ttmnv_checker u_ttmnv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_note   (rsp_chan.note_number),
   .rsp_volume (rsp_chan.volume_tenths)
);
